// ===== rtl/core/cfa_pkg.sv =====
`default_nettype none
package cfa_pkg;

   localparam int FRAC_BITS_DEF = 32;
   localparam int MAX_TERMS_DEF = 48;

   localparam int REG_W     = 32;
   localparam int CSR_IDX_W = 1;
   localparam int RSN_W     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TOL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIM = 1'b1;

   localparam logic [REG_W-1:0] TOL_RESET = 32'd4295;
   localparam logic [REG_W-1:0] LIM_RESET = 32'd999999;

   localparam logic [RSN_W-1:0] RSN_NEAR  = 2'd0;
   localparam logic [RSN_W-1:0] RSN_EXACT = 2'd1;
   localparam logic [RSN_W-1:0] RSN_TOL   = 2'd2;
   localparam logic [RSN_W-1:0] RSN_LIMIT = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/core/cfa_if.sv =====
`default_nettype none
interface cfa_req_if #(
   parameter int FRAC_BITS = cfa_pkg::FRAC_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS:0]   value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface cfa_rsp_if #(
   parameter int FRAC_BITS = cfa_pkg::FRAC_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic [FRAC_BITS:0]         numerator;
   logic [FRAC_BITS:0]         denominator;
   logic [cfa_pkg::RSN_W-1:0]  stop_reason;

   modport source (output valid, output numerator, output denominator,
                   output stop_reason, input ready);
   modport sink (input valid, input numerator, input denominator,
                 input stop_reason, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cfa_div.sv =====
`default_nettype none
module cfa_div #(
   parameter int W = cfa_pkg::FRAC_BITS_DEF + 1
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quot,
   output logic [W-1:0]      rem
);
   import cfa_pkg::*;

   localparam int CNT_W = $clog2(W);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_ALIGN = 2'd1;
   localparam logic [1:0] PH_SUB   = 2'd2;

   logic [1:0]       ph_ff, ph_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W:0]       d_ff, d_in;
   logic [W-1:0]     q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [W:0]       d_dbl;
   logic [W:0]       rem_ext;

   assign d_dbl   = {d_ff[W-1:0], 1'b0};
   assign rem_ext = {1'b0, rem_ff};

   always_comb begin
      ph_in   = ph_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      case (ph_ff)
         PH_IDLE: begin
            if (start) begin
               rem_in = dividend;
               d_in   = {1'b0, divisor};
               q_in   = '0;
               cnt_in = '0;
               ph_in  = PH_ALIGN;
            end
         end
         // shift the divisor up under the dividend
         PH_ALIGN: begin
            if (d_dbl <= rem_ext) begin
               d_in   = d_dbl;
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               ph_in = PH_SUB;
            end
         end
         // one quotient bit per cycle
         PH_SUB: begin
            if (d_ff <= rem_ext) begin
               rem_in = rem_ff - d_ff[W-1:0];
               q_in   = {q_ff[W-2:0], 1'b1};
            end else begin
               q_in = {q_ff[W-2:0], 1'b0};
            end
            d_in = {1'b0, d_ff[W:1]};
            if (cnt_ff == '0) begin
               ph_in   = PH_IDLE;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
            ph_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// ===== rtl/core/cfa_mac.sv =====
`default_nettype none
module cfa_mac #(
   parameter int W = cfa_pkg::FRAC_BITS_DEF + 1
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] term,
   input  wire logic [W-1:0] h_cur,
   input  wire logic [W-1:0] k_cur,
   input  wire logic [W-1:0] h_prev,
   input  wire logic [W-1:0] k_prev,
   output logic              done,
   output logic [W-1:0]      h_next,
   output logic [W-1:0]      k_next
);
   import cfa_pkg::*;

   logic         busy_ff, busy_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] ah_ff, ah_in;
   logic [W-1:0] ak_ff, ak_in;
   logic [W-1:0] acch_ff, acch_in;
   logic [W-1:0] acck_ff, acck_in;

   assign done = busy_ff && (b_ff == '0);

   always_comb begin
      busy_in = busy_ff;
      b_in    = b_ff;
      ah_in   = ah_ff;
      ak_in   = ak_ff;
      acch_in = acch_ff;
      acck_in = acck_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            b_in    = term;
            ah_in   = h_cur;
            ak_in   = k_cur;
            acch_in = h_prev;
            acck_in = k_prev;
         end
      end else if (b_ff == '0) begin
         busy_in = 1'b0;
      end else begin
         // term bits go out lsb first, both lanes share them
         if (b_ff[0]) begin
            acch_in = acch_ff + ah_ff;
            acck_in = acck_ff + ak_ff;
         end
         ah_in = {ah_ff[W-2:0], 1'b0};
         ak_in = {ak_ff[W-2:0], 1'b0};
         b_in  = {1'b0, b_ff[W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      b_ff    <= b_in;
      ah_ff   <= ah_in;
      ak_ff   <= ak_in;
      acch_ff <= acch_in;
      acck_ff <= acck_in;
   end

   assign h_next = acch_ff;
   assign k_next = acck_ff;

endmodule
`default_nettype wire

// ===== rtl/core/continued_fraction_approximator.sv =====
`default_nettype none
// channel   dir  handshake                    payload
// req_chan  in   valid/ready                  value
// rsp_chan  out  valid/ready                  numerator, denominator, stop_reason
// csr_*     in   csr_we, write only           csr_index, csr_wdata
//
// an item below the tolerance, or at one with a nonzero tolerance, skips the loop; else each
// term b runs a shift-subtract division, a serial multiply-add and a tolerance division of
// the remainder by the denominator, which dominates while the denominator is small
// reset is synchronous, with no clearing pass
// a finished item waits in the output register while the next item is taken
module continued_fraction_approximator #(
   parameter int FRAC_BITS = cfa_pkg::FRAC_BITS_DEF,
   parameter int MAX_TERMS = cfa_pkg::MAX_TERMS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cfa_req_if.sink                            req_chan,
   cfa_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [cfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cfa_pkg::REG_W-1:0]     csr_wdata
);
   import cfa_pkg::*;

   localparam int W  = FRAC_BITS + 1;
   localparam int CW = (W > REG_W) ? W : REG_W;
   localparam int IW = $clog2(MAX_TERMS + 1);
   localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOOP = 3'd1;
   localparam logic [2:0] ST_DIV1 = 3'd2;
   localparam logic [2:0] ST_MAC  = 3'd3;
   localparam logic [2:0] ST_DIV2 = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [REG_W-1:0] tol_ff, tol_in;
   logic [REG_W-1:0] lim_ff, lim_in;
   logic [W-1:0]     s_ff, s_in;
   logic [W-1:0]     r_ff, r_in;
   logic [W-1:0]     hp_ff, hp_in;
   logic [W-1:0]     kp_ff, kp_in;
   logic [W-1:0]     h_ff, h_in;
   logic [W-1:0]     k_ff, k_in;
   logic [IW-1:0]    iter_ff, iter_in;
   logic [RSN_W-1:0] rsn_ff, rsn_in;
   logic             ovld_ff, ovld_in;
   logic [W-1:0]     onum_ff, onum_in;
   logic [W-1:0]     oden_ff, oden_in;
   logic [RSN_W-1:0] orsn_ff, orsn_in;

   logic [W-1:0]  v_clamp;
   logic [CW-1:0] tol_ext;
   logic          div_start;
   logic [W-1:0]  div_a;
   logic [W-1:0]  div_b;
   logic          div_done;
   logic [W-1:0]  div_q;
   logic [W-1:0]  div_r;
   logic          mac_start;
   logic          mac_done;
   logic [W-1:0]  mac_h;
   logic [W-1:0]  mac_k;
   logic          over_limit;
   logic          close;

   assign v_clamp    = (req_chan.value > ONE) ? ONE : req_chan.value;
   assign tol_ext    = CW'(tol_ff);
   assign over_limit = CW'(div_q) > CW'(lim_ff);
   assign close      = (CW'(div_q) < tol_ext) || ((CW'(div_q) == tol_ext) && (div_r == '0));

   assign div_start = ((state_ff == ST_LOOP) && (iter_ff != IW'(MAX_TERMS)) && (r_ff != '0))
                   || ((state_ff == ST_MAC) && mac_done && (r_ff != '0));
   assign div_a     = (state_ff == ST_LOOP) ? s_ff : r_ff;
   assign div_b     = (state_ff == ST_LOOP) ? r_ff : mac_k;
   assign mac_start = (state_ff == ST_DIV1) && div_done && !over_limit;

   cfa_div #(.W(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   cfa_mac #(.W(W)) u_mac (
      .clock  (clock),
      .reset  (reset),
      .start  (mac_start),
      .term   (div_q),
      .h_cur  (h_ff),
      .k_cur  (k_ff),
      .h_prev (hp_ff),
      .k_prev (kp_ff),
      .done   (mac_done),
      .h_next (mac_h),
      .k_next (mac_k)
   );

   always_comb begin
      state_in = state_ff;
      tol_in   = tol_ff;
      lim_in   = lim_ff;
      s_in     = s_ff;
      r_in     = r_ff;
      hp_in    = hp_ff;
      kp_in    = kp_ff;
      h_in     = h_ff;
      k_in     = k_ff;
      iter_in  = iter_ff;
      rsn_in   = rsn_ff;
      ovld_in  = ovld_ff;
      onum_in  = onum_ff;
      oden_in  = oden_ff;
      orsn_in  = orsn_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_TOL: tol_in = csr_wdata;
            CSR_LIM: lim_in = csr_wdata;
            default: begin
            end
         endcase
      end

      if (ovld_ff && rsp_chan.ready) begin
         ovld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (CW'(v_clamp) < tol_ext) begin
                  h_in     = '0;
                  k_in     = W'(1);
                  rsn_in   = RSN_NEAR;
                  state_in = ST_FIN;
               end else if ((v_clamp == ONE) && (tol_ff != '0)) begin
                  h_in     = W'(1);
                  k_in     = W'(1);
                  rsn_in   = RSN_NEAR;
                  state_in = ST_FIN;
               end else begin
                  s_in     = ONE;
                  r_in     = v_clamp;
                  hp_in    = W'(1);
                  kp_in    = '0;
                  h_in     = '0;
                  k_in     = W'(1);
                  iter_in  = '0;
                  rsn_in   = RSN_LIMIT;
                  state_in = ST_LOOP;
               end
            end
         end
         ST_LOOP: begin
            if (iter_ff == IW'(MAX_TERMS)) begin
               rsn_in   = RSN_LIMIT;
               state_in = ST_FIN;
            end else if (r_ff == '0) begin
               rsn_in   = RSN_EXACT;
               state_in = ST_FIN;
            end else begin
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               if (over_limit) begin
                  rsn_in   = RSN_LIMIT;
                  state_in = ST_FIN;
               end else begin
                  s_in     = r_ff;
                  r_in     = div_r;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            if (mac_done) begin
               hp_in   = h_ff;
               kp_in   = k_ff;
               h_in    = mac_h;
               k_in    = mac_k;
               iter_in = iter_ff + IW'(1);
               if (r_ff == '0) begin
                  rsn_in   = RSN_EXACT;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_DIV2;
               end
            end
         end
         // remainder over denominator against the tolerance
         ST_DIV2: begin
            if (div_done) begin
               if (close) begin
                  rsn_in   = RSN_TOL;
                  state_in = ST_FIN;
               end else begin
                  rsn_in   = RSN_LIMIT;
                  state_in = ST_LOOP;
               end
            end
         end
         ST_FIN: begin
            if (!ovld_ff || rsp_chan.ready) begin
               ovld_in  = 1'b1;
               onum_in  = h_ff;
               oden_in  = k_ff;
               orsn_in  = rsn_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tol_ff   <= TOL_RESET;
         lim_ff   <= LIM_RESET;
         ovld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tol_ff   <= tol_in;
         lim_ff   <= lim_in;
         ovld_ff  <= ovld_in;
      end
      s_ff    <= s_in;
      r_ff    <= r_in;
      hp_ff   <= hp_in;
      kp_ff   <= kp_in;
      h_ff    <= h_in;
      k_ff    <= k_in;
      iter_ff <= iter_in;
      rsn_ff  <= rsn_in;
      onum_ff <= onum_in;
      oden_ff <= oden_in;
      orsn_ff <= orsn_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = ovld_ff;
   assign rsp_chan.numerator   = onum_ff;
   assign rsp_chan.denominator = oden_ff;
   assign rsp_chan.stop_reason = orsn_ff;

   a_out_fraction: assert property (@(posedge clock) disable iff (reset)
      ovld_ff |-> ((oden_ff != '0) && (onum_ff <= oden_ff)))
      else $error("result fraction out of range");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_DIV1) || (state_ff == ST_DIV2)))
      else $error("divider finished outside a division state");

   a_mac_done_state: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_MAC))
      else $error("multiply-add finished outside its state");

   a_div2_divisor: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MAC) && mac_done && (r_ff != '0)) |-> (mac_k != '0))
      else $error("tolerance division by zero denominator");

endmodule
`default_nettype wire

// ===== bench/convergent_checker.sv =====
module convergent_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cfa_req_if                                 req_mon,
   cfa_rsp_if                                 rsp_mon,
   input  wire logic                          csr_we,
   input  wire logic [cfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cfa_pkg::REG_W-1:0]     csr_wdata,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 checked,
   output logic [3:0]                         reasons_seen
);
   import cfa_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam logic [63:0] ONE_FIX = 64'd1 << FB;

   typedef struct packed {
      logic [FB:0]      numerator;
      logic [FB:0]      denominator;
      logic [RSN_W-1:0] stop_reason;
   } convergent_type;

   convergent_type   expected_convergents[$];
   logic [REG_W-1:0] tolerance;
   logic [REG_W-1:0] quotient_cap;

   function automatic convergent_type best_convergent(input logic [FB:0] value_in,
                                                      input logic [REG_W-1:0] tol,
                                                      input logic [REG_W-1:0] cap);
      logic [63:0]      v, s, r, hp, kp, h, k, b, nr, nh, nk, q, m;
      logic [RSN_W-1:0] why;
      convergent_type   res;
      bit               done;
      int               step;
      v = 64'(value_in);
      if (v > ONE_FIX)
         v = ONE_FIX;
      if (v < 64'(tol)) begin
         res.numerator = '0;
         res.denominator = (FB+1)'(1);
         res.stop_reason = RSN_NEAR;
         return res;
      end
      if (v == ONE_FIX && tol != '0) begin
         res.numerator = (FB+1)'(1);
         res.denominator = (FB+1)'(1);
         res.stop_reason = RSN_NEAR;
         return res;
      end
      s = ONE_FIX;
      r = v;
      hp = 64'd1;
      kp = '0;
      h = '0;
      k = 64'd1;
      why = RSN_LIMIT;
      done = 1'b0;
      for (step = 0; step < MAX_TERMS_DEF && !done; step++) begin
         if (r == '0) begin
            why = RSN_EXACT;
            done = 1'b1;
         end else begin
            b = s / r;
            if (b > 64'(cap)) begin
               why = RSN_LIMIT;
               done = 1'b1;
            end else begin
               nr = s - b * r;
               s = r;
               r = nr;
               nh = b * h + hp;
               nk = b * k + kp;
               hp = h;
               kp = k;
               h = nh;
               k = nk;
               if (r == '0) begin
                  why = RSN_EXACT;
                  done = 1'b1;
               end else begin
                  q = r / k;
                  m = r % k;
                  if (q < 64'(tol) || (q == 64'(tol) && m == '0)) begin
                     why = RSN_TOL;
                     done = 1'b1;
                  end else begin
                     why = RSN_LIMIT;
                  end
               end
            end
         end
      end
      res.numerator = h[FB:0];
      res.denominator = k[FB:0];
      res.stop_reason = why;
      return res;
   endfunction

   always @(posedge clock) begin
      convergent_type want;
      if (reset) begin
         tolerance = TOL_RESET;
         quotient_cap = LIM_RESET;
         fail_count <= 0;
         checked <= 0;
         reasons_seen <= '0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            checked <= checked + 1;
            reasons_seen[rsp_mon.stop_reason] <= 1'b1;
            if (expected_convergents.size() == 0) begin
               $error("result with no item outstanding: %0d/%0d reason %0d",
                      rsp_mon.numerator, rsp_mon.denominator, rsp_mon.stop_reason);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_convergents.pop_front();
               if (rsp_mon.numerator !== want.numerator ||
                   rsp_mon.denominator !== want.denominator ||
                   rsp_mon.stop_reason !== want.stop_reason)
                  fail_count <= fail_count + 1;
               if (rsp_mon.numerator !== want.numerator)
                  $error("numerator mismatch: expected %0d, got %0d",
                         want.numerator, rsp_mon.numerator);
               if (rsp_mon.denominator !== want.denominator)
                  $error("denominator mismatch: expected %0d, got %0d",
                         want.denominator, rsp_mon.denominator);
               if (rsp_mon.stop_reason !== want.stop_reason)
                  $error("stop_reason mismatch: expected %0d, got %0d",
                         want.stop_reason, rsp_mon.stop_reason);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_convergents.insert(expected_convergents.size(),
                                        best_convergent(req_mon.value, tolerance,
                                                        quotient_cap));
         if (csr_we) begin
            if (csr_index == CSR_TOL)
               tolerance = csr_wdata;
            else if (csr_index == CSR_LIM)
               quotient_cap = csr_wdata;
         end
      end
      pending <= expected_convergents.size();
   end

endmodule

// ===== bench/continued_fraction_approximator_tb.sv =====
module continued_fraction_approximator_tb;
   import cfa_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam logic [FB:0] ONE_FIX = 33'h1_0000_0000;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 175;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wdata;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int items_sent = 0;
   int settings_used = 1;

   int         fail_count;
   int         pending;
   int         checked;
   logic [3:0] reasons_seen;

   cfa_req_if req_bus ();
   cfa_rsp_if rsp_bus ();

   continued_fraction_approximator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   convergent_checker convergent_chk (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked      (checked),
      .reasons_seen (reasons_seen)
   );

   always #6 clock = ~clock;

   // result side backpressure, with an occasional long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         hold_left <= 600;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_value(input logic [FB:0] v);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic wait_idle;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_regs(input logic [REG_W-1:0] tol, input logic [REG_W-1:0] cap);
      csr_we <= 1'b1;
      csr_index <= CSR_TOL;
      csr_wdata <= tol;
      @(posedge clock);
      csr_index <= CSR_LIM;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      #(12 * 40_000_000);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [FB:0]      v;
      logic [63:0]      wide;
      int unsigned      p, q;
      logic [REG_W-1:0] tol, cap;
      int               phase, n;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      csr_we = 1'b0;
      csr_index = CSR_TOL;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 19;
      rx_idle_pct = 78;

      // reset settings
      send_value('0);
      send_value(33'd4294);
      send_value(33'd4295);
      send_value(33'h0_8000_0000);
      send_value(33'h0_5555_5555);
      send_value(33'h0_9E37_79B9);
      send_value(33'h0_243F_6A88);
      send_value(33'h0_FFFF_FFFF);
      send_value(ONE_FIX);
      send_value(ONE_FIX + 1);
      send_value(33'h1_FFFF_FFFF);
      wait_idle();

      // zero tolerance, widest limit
      program_regs('0, 32'hFFFF_FFFF);
      send_value('0);
      send_value(33'd1);
      send_value(33'd2);
      send_value(ONE_FIX);
      send_value(33'h0_9E37_79B9);
      send_value(33'h0_AAAA_AAAB);
      send_value(33'h0_FFFF_FFFF);
      wait_idle();

      // widest tolerance, limit of one
      program_regs(32'hFFFF_FFFF, 32'd1);
      send_value(33'h0_1234_5678);
      send_value(ONE_FIX);
      send_value(33'h1_FFFF_FFFF);
      wait_idle();

      // zero limit: first quotient always over
      program_regs('0, '0);
      send_value(33'h0_8000_0000);
      wait_idle();

      program_regs(32'd1, 32'd1);
      send_value(33'h0_8000_0000);
      send_value(33'h0_C000_0000);
      wait_idle();

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase < 3) begin
            tx_idle_pct = 19;
            rx_idle_pct = 78;
         end else if (phase < 6) begin
            tx_idle_pct = 78;
            rx_idle_pct = 19;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case ($urandom_range(5))
            0: tol = '0;
            1: tol = TOL_RESET;
            2: tol = $urandom_range(255, 1);
            3: tol = $urandom_range(1 << 20, 256);
            4: tol = $urandom;
            default: tol = 32'hFFFF_FFFF;
         endcase
         case ($urandom_range(5))
            0: cap = 32'd1;
            1: cap = $urandom_range(16, 2);
            2: cap = $urandom_range(100000, 17);
            3: cap = LIM_RESET;
            4: cap = $urandom | 32'd1;
            default: cap = 32'hFFFF_FFFF;
         endcase
         // large tolerances swallow nearly every value, so keep them rare
         if (tol > 32'h0010_0000 && $urandom_range(3) != 0)
            tol = tol >> 16;
         program_regs(tol, cap);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == 30 && (phase == 1 || phase == 7))
               hold_asked <= hold_asked + 1;
            case ($urandom_range(15))
               0: v = {1'($urandom_range(1)), $urandom};
               1: v = ONE_FIX;
               2: v = 33'($urandom_range(65535));
               3: v = ONE_FIX - 33'($urandom_range(65535));
               4: v = 33'($urandom_range(3));
               5, 6: begin
                  q = $urandom_range(1000, 2);
                  p = $urandom_range(q);
                  wide = (64'(p) << FB) / 64'(q) + 64'($urandom_range(2));
                  v = wide[FB:0];
               end
               default: v = {1'b0, $urandom};
            endcase
            send_value(v);
         end
         wait_idle();
      end

      $display("%0d values sent over %0d register settings, %0d convergents checked",
               items_sent, settings_used, checked);
      $display("stop reasons seen: near %0b, exact %0b, tolerance %0b, limit %0b",
               reasons_seen[RSN_NEAR], reasons_seen[RSN_EXACT],
               reasons_seen[RSN_TOL], reasons_seen[RSN_LIMIT]);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/cfa_pkg.sv
rtl/core/cfa_if.sv
rtl/core/cfa_div.sv
rtl/core/cfa_mac.sv
rtl/core/continued_fraction_approximator.sv
bench/convergent_checker.sv
bench/continued_fraction_approximator_tb.sv
